[design/gimli_pkg.sv]
// ----------------------------------------------------------------------------
// gimli_pkg
// Shared types and constants for the Gimli-384 permutation pipeline.
// ----------------------------------------------------------------------------
package gimli_pkg;

    // number of 32-bit words in one state
    localparam int unsigned WORDS = 12;

    // width of a round number (rounds run from at most 24 down to 1)
    localparam int unsigned ROUND_W = 5;

    // base of the round constant folded into word 0
    localparam logic [31:0] RC_BASE = 32'h9e377900;

    // round number
    typedef logic [ROUND_W-1:0] round_t;

    // one 384-bit state: word c top row, 4+c middle, 8+c bottom
    typedef logic [WORDS-1:0][31:0] state_t;

endpackage

[design/gimli_stream_if.sv]
// ----------------------------------------------------------------------------
// gimli_load_if / gimli_result_if
// Valid/ready channels for the input state and the permuted state.
// ----------------------------------------------------------------------------
interface gimli_load_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_in_0;
    logic [31:0] word_in_1;
    logic [31:0] word_in_2;
    logic [31:0] word_in_3;
    logic [31:0] word_in_4;
    logic [31:0] word_in_5;
    logic [31:0] word_in_6;
    logic [31:0] word_in_7;
    logic [31:0] word_in_8;
    logic [31:0] word_in_9;
    logic [31:0] word_in_10;
    logic [31:0] word_in_11;

    modport source
    (
        output valid,
        output word_in_0, word_in_1, word_in_2, word_in_3,
        output word_in_4, word_in_5, word_in_6, word_in_7,
        output word_in_8, word_in_9, word_in_10, word_in_11,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  word_in_0, word_in_1, word_in_2, word_in_3,
        input  word_in_4, word_in_5, word_in_6, word_in_7,
        input  word_in_8, word_in_9, word_in_10, word_in_11,
        output ready
    );
endinterface

interface gimli_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_out_0;
    logic [31:0] word_out_1;
    logic [31:0] word_out_2;
    logic [31:0] word_out_3;
    logic [31:0] word_out_4;
    logic [31:0] word_out_5;
    logic [31:0] word_out_6;
    logic [31:0] word_out_7;
    logic [31:0] word_out_8;
    logic [31:0] word_out_9;
    logic [31:0] word_out_10;
    logic [31:0] word_out_11;

    modport source
    (
        output valid,
        output word_out_0, word_out_1, word_out_2, word_out_3,
        output word_out_4, word_out_5, word_out_6, word_out_7,
        output word_out_8, word_out_9, word_out_10, word_out_11,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  word_out_0, word_out_1, word_out_2, word_out_3,
        input  word_out_4, word_out_5, word_out_6, word_out_7,
        input  word_out_8, word_out_9, word_out_10, word_out_11,
        output ready
    );
endinterface

[design/gimli_round.sv]
// ----------------------------------------------------------------------------
// gimli_round
// One pipeline stage: a full Gimli round (SP-box on four columns, then the
// swap and constant chosen by the round number), followed by a stage register.
// ----------------------------------------------------------------------------
module gimli_round
(
    input  logic              clk,
    input  logic              rst_n,
    input  gimli_pkg::round_t rnd,
    input  logic              up_valid,
    output logic              up_ready,
    input  gimli_pkg::state_t up_state,
    output logic              down_valid,
    input  logic              down_ready,
    output gimli_pkg::state_t down_state
);

    logic              valid_reg;
    logic              valid_next;
    gimli_pkg::state_t state_reg;
    gimli_pkg::state_t state_next;

    // round function
    always_comb
    begin
        logic [31:0]       x;
        logic [31:0]       y;
        logic [31:0]       z;
        gimli_pkg::state_t sp;
        sp = up_state;
        // sp-box, columns are independent
        for (int c = 0; c < 4; c++)
        begin
            x = {up_state[c][7:0], up_state[c][31:8]};
            y = {up_state[c+4][22:0], up_state[c+4][31:23]};
            z = up_state[c+8];
            sp[c+8] = x ^ (z << 1) ^ ((y & z) << 2);
            sp[c+4] = y ^ x ^ ((x | z) << 1);
            sp[c]   = z ^ y ^ ((x & y) << 3);
        end
        state_next = sp;
        // linear layer by round number mod 4
        case (rnd[1:0])
            2'd0:
            begin
                state_next[0] = sp[1] ^ gimli_pkg::RC_BASE
                                ^ {{(32-gimli_pkg::ROUND_W){1'b0}}, rnd};
                state_next[1] = sp[0];
                state_next[2] = sp[3];
                state_next[3] = sp[2];
            end
            2'd2:
            begin
                state_next[0] = sp[2];
                state_next[1] = sp[3];
                state_next[2] = sp[0];
                state_next[3] = sp[1];
            end
            default:
            begin
                state_next = sp;
            end
        endcase
    end

    // stage advances when empty or when the next stage takes its beat
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            state_reg <= state_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_state = state_reg;

endmodule

[design/gimli24_permutation_top.sv]
// ----------------------------------------------------------------------------
// gimli24_permutation_top
// Gimli-384 permutation as a pipeline of one round per stage.
// ----------------------------------------------------------------------------
// Each accepted beat on load carries a full 384-bit state; the permuted state
// leaves on result after passing every stage. There is one register stage per
// round, rounds ROUND_COUNT down to 1, and a new state can enter every cycle
// while load ready is high. A stall on result holds each occupied stage that
// has only occupied stages after it; empty stages still fill, so up to
// ROUND_COUNT states wait inside before load ready drops. The last stage
// register is the output register. No state is kept between beats.
module gimli24_permutation_top
#(
    parameter int unsigned ROUND_COUNT = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    gimli_load_if.sink      load,
    gimli_result_if.source  result
);

    logic              valid_chain [ROUND_COUNT+1];
    logic              ready_chain [ROUND_COUNT+1];
    gimli_pkg::state_t state_chain [ROUND_COUNT+1];

    // input beat into the head of the pipe
    assign valid_chain[0] = load.valid;
    assign load.ready     = ready_chain[0];
    assign state_chain[0] = {load.word_in_11, load.word_in_10, load.word_in_9,
                             load.word_in_8, load.word_in_7, load.word_in_6,
                             load.word_in_5, load.word_in_4, load.word_in_3,
                             load.word_in_2, load.word_in_1, load.word_in_0};

    // one stage per round, round number counts down
    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_round
        gimli_round u_round
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .rnd        (gimli_pkg::ROUND_W'(ROUND_COUNT - i)),
            .up_valid   (valid_chain[i]),
            .up_ready   (ready_chain[i]),
            .up_state   (state_chain[i]),
            .down_valid (valid_chain[i+1]),
            .down_ready (ready_chain[i+1]),
            .down_state (state_chain[i+1])
        );
    end

    // output beat from the last stage
    assign ready_chain[ROUND_COUNT] = result.ready;
    assign result.valid       = valid_chain[ROUND_COUNT];
    assign result.word_out_0  = state_chain[ROUND_COUNT][0];
    assign result.word_out_1  = state_chain[ROUND_COUNT][1];
    assign result.word_out_2  = state_chain[ROUND_COUNT][2];
    assign result.word_out_3  = state_chain[ROUND_COUNT][3];
    assign result.word_out_4  = state_chain[ROUND_COUNT][4];
    assign result.word_out_5  = state_chain[ROUND_COUNT][5];
    assign result.word_out_6  = state_chain[ROUND_COUNT][6];
    assign result.word_out_7  = state_chain[ROUND_COUNT][7];
    assign result.word_out_8  = state_chain[ROUND_COUNT][8];
    assign result.word_out_9  = state_chain[ROUND_COUNT][9];
    assign result.word_out_10 = state_chain[ROUND_COUNT][10];
    assign result.word_out_11 = state_chain[ROUND_COUNT][11];

endmodule
